[rtl/kmi_pkg.sv]
// Shared types, constants and helpers for the keyframe motion interpolator.
// No dependencies; imported by every module of the block but kmi_ram.
package kmi_pkg;

  localparam int KMI_MAX_KEYS = 16;

  localparam int DATA_W  = 32;            // Q16.16 values
  localparam int KC_W    = 5;             // key_count register width
  localparam int NUM_W   = DATA_W + KC_W; // elapsed * (n - 1)
  localparam int Q_W     = NUM_W + 16;    // quotient of (num << 16) / duration
  localparam int DCNT_W  = $clog2(Q_W);
  localparam int CIDX_W  = 3;             // config register index width
  localparam int CDAT_W  = 48;            // config data width
  localparam int SAT_W   = 37;

  localparam logic [1:0] REQ_TICK     = 2'd0;
  localparam logic [1:0] REQ_LOAD_POS = 2'd1;
  localparam logic [1:0] REQ_LOAD_ROT = 2'd2;
  localparam logic [1:0] REQ_RESTART  = 2'd3;

  localparam logic [CIDX_W-1:0] REG_DURATION  = 3'd0;
  localparam logic [CIDX_W-1:0] REG_KEY_COUNT = 3'd1;
  localparam logic [CIDX_W-1:0] REG_BASIS_FWD = 3'd2;
  localparam logic [CIDX_W-1:0] REG_BASIS_RGT = 3'd3;
  localparam logic [CIDX_W-1:0] REG_BASIS_UP  = 3'd4;

  typedef struct packed {
    logic       cfg_wr;
    logic       capture;   // input transaction taken
    logic       clear;     // restart
    logic       key_wr;    // write one key component
    logic       sum;       // advance elapsed time
    logic       mul;       // num = elapsed * (n - 1)
    logic       div_ld;
    logic       div_step;
    logic       rd_b;      // second read of a component, latch first
    logic       interp;
    logic       update;
    logic       mul_b;     // basis product
    logic       acc_b;     // basis accumulate
    logic [1:0] comp;
    logic [1:0] row;
  } kmi_cmd_t;

  typedef struct packed {
    logic done;
  } kmi_sts_t;

  function automatic logic [DATA_W-1:0] kmi_sat(input logic signed [SAT_W-1:0] v);
    logic hi_same;
    hi_same = (v[SAT_W-1:DATA_W-1] == '0) || (v[SAT_W-1:DATA_W-1] == '1);
    if (hi_same) return v[DATA_W-1:0];
    else if (v[SAT_W-1]) return 32'h8000_0000;
    else return 32'h7fff_ffff;
  endfunction

endpackage

[rtl/kmi_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module kmi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 48
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/kmi_ctrl.sv]
// Sequencer for the keyframe motion interpolator: handshakes and step commands.
// Depends on kmi_pkg.
module kmi_ctrl import kmi_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] req_type_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  output kmi_cmd_t   cmd_o,
  input  kmi_sts_t   sts_i
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LOAD = 4'd1;
  localparam logic [3:0] S_SUM  = 4'd2;
  localparam logic [3:0] S_MUL  = 4'd3;
  localparam logic [3:0] S_DLD  = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_RDA  = 4'd6;
  localparam logic [3:0] S_RDB  = 4'd7;
  localparam logic [3:0] S_INT  = 4'd8;
  localparam logic [3:0] S_UPD  = 4'd9;
  localparam logic [3:0] S_MB   = 4'd10;
  localparam logic [3:0] S_AB   = 4'd11;
  localparam logic [3:0] S_OUT  = 4'd12;

  logic [3:0]        state_q, state_d;
  logic [1:0]        comp_q, comp_d;
  logic [1:0]        row_q, row_d;
  logic [DCNT_W-1:0] dcnt_q, dcnt_d;
  logic              in_acc;

  assign in_acc      = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign cfg_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    comp_d  = comp_q;
    row_d   = row_q;
    dcnt_d  = dcnt_q;
    case (state_q)
      S_IDLE: begin
        comp_d = 2'd0;
        row_d  = 2'd0;
        if (in_valid_i) begin
          case (req_type_i)
            REQ_TICK:                   state_d = S_SUM;
            REQ_LOAD_POS, REQ_LOAD_ROT: state_d = S_LOAD;
            default:                    state_d = S_IDLE;
          endcase
        end
      end
      S_LOAD: begin
        comp_d = comp_q + 2'd1;
        if (comp_q == 2'd2) state_d = S_IDLE;
      end
      S_SUM: state_d = S_MUL;
      S_MUL: state_d = sts_i.done ? S_RDA : S_DLD;
      S_DLD: begin
        dcnt_d  = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        dcnt_d = dcnt_q + 1'b1;
        if (dcnt_q == DCNT_W'(Q_W - 1)) state_d = S_RDA;
      end
      S_RDA: state_d = S_RDB;
      S_RDB: state_d = S_INT;
      S_INT: state_d = S_UPD;
      S_UPD: begin
        if (comp_q == 2'd2) begin
          comp_d  = 2'd0;
          state_d = S_MB;
        end else begin
          comp_d  = comp_q + 2'd1;
          state_d = S_RDA;
        end
      end
      S_MB: state_d = S_AB;
      S_AB: begin
        state_d = S_MB;
        if (comp_q == 2'd2) begin
          comp_d = 2'd0;
          if (row_q == 2'd2) state_d = S_OUT;
          else row_d = row_q + 2'd1;
        end else begin
          comp_d = comp_q + 2'd1;
        end
      end
      S_OUT: if (!out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.cfg_wr   = cfg_valid_i && cfg_ready_o;
    cmd_o.capture  = in_acc;
    cmd_o.clear    = in_acc && (req_type_i == REQ_RESTART);
    cmd_o.key_wr   = (state_q == S_LOAD);
    cmd_o.sum      = (state_q == S_SUM);
    cmd_o.mul      = (state_q == S_MUL);
    cmd_o.div_ld   = (state_q == S_DLD);
    cmd_o.div_step = (state_q == S_DIV);
    cmd_o.rd_b     = (state_q == S_RDB);
    cmd_o.interp   = (state_q == S_INT);
    cmd_o.update   = (state_q == S_UPD);
    cmd_o.mul_b    = (state_q == S_MB);
    cmd_o.acc_b    = (state_q == S_AB);
    cmd_o.comp     = comp_q;
    cmd_o.row      = row_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      comp_q  <= '0;
      row_q   <= '0;
      dcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      comp_q  <= comp_d;
      row_q   <= row_d;
      dcnt_q  <= dcnt_d;
    end
  end

endmodule

[rtl/kmi_datapath.sv]
// Datapath: config registers, key tables, time divider, interpolation, basis MAC.
// Depends on kmi_pkg and kmi_ram.
module kmi_datapath import kmi_pkg::*; #(
  parameter int MAX_KEYS = KMI_MAX_KEYS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  kmi_cmd_t                 cmd_i,
  output kmi_sts_t                 sts_o,
  input  logic [CIDX_W-1:0]        cfg_index_i,
  input  logic [CDAT_W-1:0]        cfg_data_i,
  input  logic [1:0]               req_type_i,
  input  logic [3:0]               key_index_i,
  input  logic signed [DATA_W-1:0] key_x_i,
  input  logic signed [DATA_W-1:0] key_y_i,
  input  logic signed [DATA_W-1:0] key_z_i,
  input  logic [DATA_W-1:0]        delta_time_i,
  output logic signed [DATA_W-1:0] move_x_o,
  output logic signed [DATA_W-1:0] move_y_o,
  output logic signed [DATA_W-1:0] move_z_o,
  output logic signed [DATA_W-1:0] turn_pitch_o,
  output logic signed [DATA_W-1:0] turn_yaw_o,
  output logic signed [DATA_W-1:0] turn_roll_o,
  output logic                     finished_o
);

  localparam int DEPTH = MAX_KEYS * 3;
  localparam int AW    = $clog2(DEPTH);

  logic [DATA_W-1:0]        dur_q;
  logic [KC_W-1:0]          kcnt_q;
  logic [CDAT_W-1:0]        basis_q [3];
  logic [1:0]               req_q;
  logic [3:0]               slot_q;
  logic [DATA_W-1:0]        key_q [3];
  logic [DATA_W-1:0]        delta_q;
  logic [DATA_W-1:0]        elapsed_q;
  logic                     done_q;
  logic [NUM_W-1:0]         num_q;
  logic [DATA_W:0]          rem_q;
  logic [Q_W-1:0]           dq_q;
  logic signed [DATA_W-1:0] a_pos_q, a_rot_q;
  logic signed [49:0]       ip_q, ir_q;
  logic signed [DATA_W-1:0] poff_q [3];
  logic signed [DATA_W-1:0] roff_q [3];
  logic signed [DATA_W:0]   dpos_q [3];
  logic signed [DATA_W:0]   drot_q [3];
  logic signed [48:0]       pb_q;
  logic signed [50:0]       acc_q;
  logic [DATA_W-1:0]        move_q [3];

  logic [KC_W-1:0]          n_used, nm1;
  logic [DATA_W:0]          sum;
  logic                     sum_done;
  logic [DATA_W:0]          rem_sh, rem_nx;
  logic                     q_bit;
  logic [KC_W-1:0]          seg, seg_b;
  logic [15:0]              frac;
  logic [AW-1:0]            addr_a, addr_b, raddr, waddr;
  logic                     slot_ok;
  logic [DATA_W-1:0]        pos_rd, rot_rd;
  logic signed [DATA_W:0]   diff_pos, diff_rot;
  logic signed [DATA_W-1:0] s_pos, s_rot;
  logic signed [15:0]       bcoef;
  logic signed [50:0]       acc_sum;

  // clamp key_count to [2, MAX_KEYS]
  always_comb begin
    if (kcnt_q < KC_W'(2)) n_used = KC_W'(2);
    else if (32'(kcnt_q) > MAX_KEYS) n_used = KC_W'(MAX_KEYS);
    else n_used = kcnt_q;
  end
  assign nm1 = n_used - KC_W'(1);

  assign sum      = {1'b0, elapsed_q} + {1'b0, delta_q};
  assign sum_done = (sum >= {1'b0, dur_q});

  // restoring divider, one quotient bit per step
  assign rem_sh = {rem_q[DATA_W-1:0], dq_q[Q_W-1]};
  assign q_bit  = (rem_sh >= {1'b0, dur_q});
  assign rem_nx = q_bit ? rem_sh - {1'b0, dur_q} : rem_sh;

  assign seg   = dq_q[16 +: KC_W];
  assign frac  = dq_q[15:0];
  assign seg_b = done_q ? seg : seg + KC_W'(1);

  assign addr_a  = AW'(32'(seg) * 3 + 32'(cmd_i.comp));
  assign addr_b  = AW'(32'(seg_b) * 3 + 32'(cmd_i.comp));
  assign raddr   = cmd_i.rd_b ? addr_b : addr_a;
  assign waddr   = AW'(32'(slot_q) * 3 + 32'(cmd_i.comp));
  assign slot_ok = (32'(slot_q) < MAX_KEYS);

  kmi_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.key_wr && slot_ok && (req_q == REQ_LOAD_POS)),
    .waddr_i (waddr),
    .wdata_i (key_q[cmd_i.comp]),
    .raddr_i (raddr),
    .rdata_o (pos_rd)
  );

  kmi_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_rot_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.key_wr && slot_ok && (req_q == REQ_LOAD_ROT)),
    .waddr_i (waddr),
    .wdata_i (key_q[cmd_i.comp]),
    .raddr_i (raddr),
    .rdata_o (rot_rd)
  );

  assign diff_pos = $signed({pos_rd[DATA_W-1], pos_rd}) - $signed({a_pos_q[DATA_W-1], a_pos_q});
  assign diff_rot = $signed({rot_rd[DATA_W-1], rot_rd}) - $signed({a_rot_q[DATA_W-1], a_rot_q});

  // a + floor(diff * frac / 2^16) always fits 32 bits
  assign s_pos = a_pos_q + ip_q[47:16];
  assign s_rot = a_rot_q + ir_q[47:16];

  assign bcoef   = $signed(basis_q[cmd_i.comp][{cmd_i.row, 4'b0000} +: 16]);
  assign acc_sum = acc_q + {{2{pb_q[48]}}, pb_q};

  assign sts_o.done = done_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dur_q      <= 32'h0001_0000;
      kcnt_q     <= KC_W'(2);
      basis_q[0] <= 48'h0000_0000_4000;
      basis_q[1] <= 48'h0000_4000_0000;
      basis_q[2] <= 48'h4000_0000_0000;
    end else if (cmd_i.cfg_wr) begin
      case (cfg_index_i)
        REG_DURATION:  dur_q      <= cfg_data_i[DATA_W-1:0];
        REG_KEY_COUNT: kcnt_q     <= cfg_data_i[KC_W-1:0];
        REG_BASIS_FWD: basis_q[0] <= cfg_data_i;
        REG_BASIS_RGT: basis_q[1] <= cfg_data_i;
        REG_BASIS_UP:  basis_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // motion state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q <= '0;
      done_q    <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        poff_q[i] <= '0;
        roff_q[i] <= '0;
      end
    end else begin
      if (cmd_i.clear) begin
        elapsed_q <= '0;
        for (int i = 0; i < 3; i++) begin
          poff_q[i] <= '0;
          roff_q[i] <= '0;
        end
      end
      if (cmd_i.sum) begin
        done_q    <= sum_done;
        elapsed_q <= sum_done ? dur_q : sum[DATA_W-1:0];
      end
      if (cmd_i.update) begin
        poff_q[cmd_i.comp] <= s_pos;
        roff_q[cmd_i.comp] <= s_rot;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q    <= req_type_i;
      slot_q   <= key_index_i;
      key_q[0] <= key_x_i;
      key_q[1] <= key_y_i;
      key_q[2] <= key_z_i;
      delta_q  <= delta_time_i;
    end
    if (cmd_i.sum && sum_done) begin
      dq_q <= Q_W'({nm1, 16'h0000});  // sample the last key, zero fraction
    end
    if (cmd_i.mul) begin
      num_q <= NUM_W'(elapsed_q) * NUM_W'(nm1);
    end
    if (cmd_i.div_ld) begin
      rem_q <= '0;
      dq_q  <= {num_q, 16'h0000};
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_nx;
      dq_q  <= {dq_q[Q_W-2:0], q_bit};
    end
    if (cmd_i.rd_b) begin
      a_pos_q <= pos_rd;
      a_rot_q <= rot_rd;
    end
    if (cmd_i.interp) begin
      ip_q <= diff_pos * $signed({1'b0, frac});
      ir_q <= diff_rot * $signed({1'b0, frac});
    end
    if (cmd_i.update) begin
      dpos_q[cmd_i.comp] <= $signed({s_pos[DATA_W-1], s_pos})
                          - $signed({poff_q[cmd_i.comp][DATA_W-1], poff_q[cmd_i.comp]});
      drot_q[cmd_i.comp] <= $signed({s_rot[DATA_W-1], s_rot})
                          - $signed({roff_q[cmd_i.comp][DATA_W-1], roff_q[cmd_i.comp]});
      acc_q <= '0;
    end
    if (cmd_i.mul_b) begin
      pb_q <= bcoef * dpos_q[cmd_i.comp];
    end
    if (cmd_i.acc_b) begin
      if (cmd_i.comp == 2'd2) begin
        move_q[cmd_i.row] <= kmi_sat(acc_sum[50:14]);
        acc_q             <= '0;
      end else begin
        acc_q <= acc_sum;
      end
    end
  end

  assign move_x_o     = move_q[0];
  assign move_y_o     = move_q[1];
  assign move_z_o     = move_q[2];
  assign turn_pitch_o = kmi_sat(SAT_W'(drot_q[1]));
  assign turn_yaw_o   = kmi_sat(SAT_W'(drot_q[2]));
  assign turn_roll_o  = kmi_sat(SAT_W'(drot_q[0]));
  assign finished_o   = done_q;

endmodule

[rtl/keyframe_motion_interpolator.sv]
// Top level of the keyframe motion interpolator: sequencer plus datapath.
// Depends on kmi_pkg, kmi_ctrl, kmi_datapath (and kmi_ram below it).
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------------------
//  input    | in_valid_i / in_stall_o   | req_type, key_index, key_x/y/z, delta
//  output   | out_valid_o / out_stall_i | move_x/y/z, turn_pitch/yaw/roll, fin
//  config   | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One item at a time. A restart clears elapsed time and offsets as it is taken, a key
// load does one table write per component. A tick inside the sequence steps through
// time sum, product and divider load, the bit-serial time divider, key reads and
// interpolation, and the shared basis multiply-accumulate. A finishing tick skips
// the divider load and steps. The result holds while out_stall_i is high; input
// stalls until it is taken. Reset clears control, the done flag, elapsed time and
// offsets and restores the config defaults; no sweep.
module keyframe_motion_interpolator import kmi_pkg::*; #(
  parameter int MAX_KEYS = KMI_MAX_KEYS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               req_type_i,
  input  logic [3:0]               key_index_i,
  input  logic signed [DATA_W-1:0] key_x_i,
  input  logic signed [DATA_W-1:0] key_y_i,
  input  logic signed [DATA_W-1:0] key_z_i,
  input  logic [DATA_W-1:0]        delta_time_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] move_x_o,
  output logic signed [DATA_W-1:0] move_y_o,
  output logic signed [DATA_W-1:0] move_z_o,
  output logic signed [DATA_W-1:0] turn_pitch_o,
  output logic signed [DATA_W-1:0] turn_yaw_o,
  output logic signed [DATA_W-1:0] turn_roll_o,
  output logic                     finished_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CIDX_W-1:0]        cfg_index_i,
  input  logic [CDAT_W-1:0]        cfg_data_i
);

  kmi_cmd_t cmd;
  kmi_sts_t sts;

  kmi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  kmi_datapath #(.MAX_KEYS(MAX_KEYS)) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .req_type_i   (req_type_i),
    .key_index_i  (key_index_i),
    .key_x_i      (key_x_i),
    .key_y_i      (key_y_i),
    .key_z_i      (key_z_i),
    .delta_time_i (delta_time_i),
    .move_x_o     (move_x_o),
    .move_y_o     (move_y_o),
    .move_z_o     (move_z_o),
    .turn_pitch_o (turn_pitch_o),
    .turn_yaw_o   (turn_yaw_o),
    .turn_roll_o  (turn_roll_o),
    .finished_o   (finished_o)
  );

endmodule

[tb/kmi_checker.sv]
// Scoreboard for the keyframe motion interpolator: tracks config and input
// transactions, predicts each tick result and compares output transactions.
// Depends on kmi_pkg.
`timescale 1ns / 1ps

module kmi_checker import kmi_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic [1:0]          req_type_i,
  input  logic [3:0]          key_index_i,
  input  logic [DATA_W-1:0]   key_x_i,
  input  logic [DATA_W-1:0]   key_y_i,
  input  logic [DATA_W-1:0]   key_z_i,
  input  logic [DATA_W-1:0]   delta_time_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic [DATA_W-1:0]   move_x_i,
  input  logic [DATA_W-1:0]   move_y_i,
  input  logic [DATA_W-1:0]   move_z_i,
  input  logic [DATA_W-1:0]   turn_pitch_i,
  input  logic [DATA_W-1:0]   turn_yaw_i,
  input  logic [DATA_W-1:0]   turn_roll_i,
  input  logic                finished_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CIDX_W-1:0]   cfg_index_i,
  input  logic [CDAT_W-1:0]   cfg_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  typedef struct {
    logic [DATA_W-1:0] mx, my, mz, tp, ty, tr;
    logic              fin;
  } motion_t;

  motion_t           motion_q[$];
  logic [31:0]       dur_r;
  logic [4:0]        kcnt_r;
  logic [47:0]       basis_r[3];
  longint            pos_tab[KMI_MAX_KEYS*3];
  longint            rot_tab[KMI_MAX_KEYS*3];
  logic [31:0]       elapsed_r;
  longint            pos_off[3];
  longint            rot_off[3];
  int                fails = 0;

  assign fail_count_o = fails;
  assign pending_o    = motion_q.size();

  function automatic logic [31:0] clip32(input longint v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic motion_t predict_tick(input logic [31:0] dt);
    motion_t          m;
    longint unsigned  total, num;
    longint           frac, a, b, s, acc;
    longint           dp[3], dr[3];
    int               n, seg;
    logic             done;
    n = kcnt_r < 2 ? 2 : (kcnt_r > KMI_MAX_KEYS ? KMI_MAX_KEYS : int'(kcnt_r));
    total = longint'(elapsed_r) + longint'(dt);
    done = !(total < longint'(dur_r));
    if (!done) begin
      elapsed_r = total[31:0];
      num  = longint'(elapsed_r) * longint'(n - 1);
      seg  = int'(num / dur_r);
      frac = longint'(((num % dur_r) << 16) / dur_r);
      for (int c = 0; c < 3; c++) begin
        a = pos_tab[seg*3+c];
        b = pos_tab[(seg+1)*3+c];
        s = a + (((b - a) * frac) >>> 16);
        dp[c] = s - pos_off[c];
        pos_off[c] = s;
        a = rot_tab[seg*3+c];
        b = rot_tab[(seg+1)*3+c];
        s = a + (((b - a) * frac) >>> 16);
        dr[c] = s - rot_off[c];
        rot_off[c] = s;
      end
    end else begin
      elapsed_r = dur_r;
      for (int c = 0; c < 3; c++) begin
        dp[c] = pos_tab[(n-1)*3+c] - pos_off[c];
        pos_off[c] = pos_tab[(n-1)*3+c];
        dr[c] = rot_tab[(n-1)*3+c] - rot_off[c];
        rot_off[c] = rot_tab[(n-1)*3+c];
      end
    end
    for (int r = 0; r < 3; r++) begin
      acc = 0;
      for (int c = 0; c < 3; c++)
        acc += longint'($signed(basis_r[c][16*r +: 16])) * dp[c];
      case (r)
        0: m.mx = clip32(acc >>> 14);
        1: m.my = clip32(acc >>> 14);
        default: m.mz = clip32(acc >>> 14);
      endcase
    end
    m.tp  = clip32(dr[1]);
    m.ty  = clip32(dr[2]);
    m.tr  = clip32(dr[0]);
    m.fin = done;
    return m;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s expected %0d got %0d", name, $signed(exp_v), $signed(act_v));
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    motion_t m;
    if (!rst_ni) begin
      dur_r = 32'd65536;
      kcnt_r = 5'd2;
      basis_r[0] = 48'd16384;
      basis_r[1] = 48'd1073741824;
      basis_r[2] = 48'd70368744177664;
      elapsed_r = '0;
      for (int c = 0; c < 3; c++) begin
        pos_off[c] = 0;
        rot_off[c] = 0;
      end
      motion_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (motion_q.size() == 0) begin
          $error("output transaction with no result expected");
          fails++;
        end else begin
          m = motion_q.pop_front();
          check_field("move_x", m.mx, move_x_i);
          check_field("move_y", m.my, move_y_i);
          check_field("move_z", m.mz, move_z_i);
          check_field("turn_pitch", m.tp, turn_pitch_i);
          check_field("turn_yaw", m.ty, turn_yaw_i);
          check_field("turn_roll", m.tr, turn_roll_i);
          check_field("finished", {31'd0, m.fin}, {31'd0, finished_i});
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_DURATION:  dur_r = cfg_data_i[31:0];
          REG_KEY_COUNT: kcnt_r = cfg_data_i[4:0];
          REG_BASIS_FWD: basis_r[0] = cfg_data_i;
          REG_BASIS_RGT: basis_r[1] = cfg_data_i;
          REG_BASIS_UP:  basis_r[2] = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        case (req_type_i)
          REQ_LOAD_POS: begin
            pos_tab[key_index_i*3+0] = longint'($signed(key_x_i));
            pos_tab[key_index_i*3+1] = longint'($signed(key_y_i));
            pos_tab[key_index_i*3+2] = longint'($signed(key_z_i));
          end
          REQ_LOAD_ROT: begin
            rot_tab[key_index_i*3+0] = longint'($signed(key_x_i));
            rot_tab[key_index_i*3+1] = longint'($signed(key_y_i));
            rot_tab[key_index_i*3+2] = longint'($signed(key_z_i));
          end
          REQ_RESTART: begin
            elapsed_r = '0;
            for (int c = 0; c < 3; c++) begin
              pos_off[c] = 0;
              rot_off[c] = 0;
            end
          end
          default: motion_q.push_back(predict_tick(delta_time_i));
        endcase
      end
    end
  end

endmodule

[tb/testbench.sv]
// Top of the keyframe motion interpolator testbench: clock, reset, stimulus
// and verdict. Depends on kmi_pkg, keyframe_motion_interpolator, kmi_checker.
`timescale 1ns / 1ps

module testbench import kmi_pkg::*;;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        req_type = REQ_RESTART;
  logic [3:0]        key_index = '0;
  logic [31:0]       key_x = '0, key_y = '0, key_z = '0, delta_time = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [31:0]       move_x, move_y, move_z, turn_pitch, turn_yaw, turn_roll;
  logic              finished;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CIDX_W-1:0] cfg_index = REG_DURATION;
  logic [CDAT_W-1:0] cfg_data = '0;
  int                fail_count, pending;
  logic              idle_on = 1'b1;
  int                stall_left = 0;

  always #5 clk = ~clk;

  keyframe_motion_interpolator dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .req_type_i(req_type), .key_index_i(key_index),
    .key_x_i(key_x), .key_y_i(key_y), .key_z_i(key_z), .delta_time_i(delta_time),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .move_x_o(move_x), .move_y_o(move_y), .move_z_o(move_z),
    .turn_pitch_o(turn_pitch), .turn_yaw_o(turn_yaw), .turn_roll_o(turn_roll),
    .finished_o(finished),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  kmi_checker u_scoreboard (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .req_type_i(req_type), .key_index_i(key_index),
    .key_x_i(key_x), .key_y_i(key_y), .key_z_i(key_z), .delta_time_i(delta_time),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .move_x_i(move_x), .move_y_i(move_y), .move_z_i(move_z),
    .turn_pitch_i(turn_pitch), .turn_yaw_i(turn_yaw), .turn_roll_i(turn_roll),
    .finished_i(finished),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver stalls in random bursts, started only while idle_on is set
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 9);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_item(input logic [1:0] rt, input logic [3:0] idx,
                           input logic [31:0] x, input logic [31:0] y,
                           input logic [31:0] z, input logic [31:0] dt);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= rt;
    key_index  <= idx;
    key_x      <= x;
    key_y      <= y;
    key_z      <= z;
    delta_time <= dt;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDAT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // lower valid, let every result drain, then cover a trailing load
  task automatic drain;
    in_valid <= 1'b0;
    @(negedge clk);
    wait (pending == 0);
    repeat (120) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_key;
    case ($urandom_range(0, 3))
      0: rand_key = $urandom;
      1: rand_key = {$urandom_range(0, 1) ? 12'hfff : 12'h000, 20'($urandom)};
      2: rand_key = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: rand_key = {16'($signed(16'($urandom_range(0, 255)) - 16'd128)), 16'($urandom)};
    endcase
  endfunction

  function automatic logic [15:0] rand_q214;
    case ($urandom_range(0, 4))
      0: rand_q214 = 16'h8000;
      1: rand_q214 = 16'h7fff;
      2: rand_q214 = 16'h4000;
      3: rand_q214 = 16'h0000;
      default: rand_q214 = 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [31:0] dur;
    logic [4:0]  kc;
    int          pick, steps;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: extreme keys at the two default slots
    send_item(REQ_LOAD_POS, 4'd0, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h0);
    send_item(REQ_LOAD_POS, 4'd1, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h0);
    send_item(REQ_LOAD_ROT, 4'd0, 32'h8000_0000, 32'h0, 32'h7fff_ffff, 32'h0);
    send_item(REQ_LOAD_ROT, 4'd1, 32'h7fff_ffff, 32'hffff_ffff, 32'h8000_0000, 32'h0);
    send_item(REQ_TICK, 4'hf, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'h0);
    send_item(REQ_TICK, 4'd0, 32'h0, 32'h0, 32'h0, 32'h0000_8000);
    // reaches the duration exactly
    send_item(REQ_TICK, 4'd0, 32'h0, 32'h0, 32'h0, 32'h0000_8000);
    // after the end every tick finishes with zero change
    send_item(REQ_TICK, 4'd0, 32'h0, 32'h0, 32'h0, 32'h1);
    send_item(REQ_RESTART, 4'd0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_item(REQ_TICK, 4'd0, 32'h0, 32'h0, 32'h0, 32'hffff_ffff);
    send_item(REQ_RESTART, 4'd0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_item(REQ_TICK, 4'd0, 32'h0, 32'h0, 32'h0, 32'h1);
    send_item(REQ_TICK, 4'd0, 32'h0, 32'h0, 32'h0, 32'h0000_fffe);
    send_item(REQ_TICK, 4'd0, 32'h0, 32'h0, 32'h0, 32'h0);
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: begin dur = 32'hffff_ffff; kc = 5'd16; end
        1: begin dur = 32'd1;         kc = 5'd2;  end
        2: begin dur = 32'd3;         kc = 5'd0;  end
        3: begin dur = 32'd65536;     kc = 5'd31; end
        default: begin
          dur = $urandom_range(0, 1) ? $urandom : $urandom_range(1, 32'h0010_0000);
          kc  = $urandom_range(2, 16);
        end
      endcase
      if (ph == 8) idle_on = 1'b0;
      write_reg(REG_DURATION, {16'h0, dur});
      write_reg(REG_KEY_COUNT, {43'h0, kc});
      if (ph == 0) begin
        write_reg(REG_BASIS_FWD, {16'h8000, 16'h8000, 16'h8000});
        write_reg(REG_BASIS_RGT, {16'h7fff, 16'h7fff, 16'h7fff});
        write_reg(REG_BASIS_UP, 48'hffff_ffff_ffff);
      end else if (ph == 3) begin
        write_reg(REG_BASIS_FWD, 48'd16384);
        write_reg(REG_BASIS_RGT, 48'd1073741824);
        write_reg(REG_BASIS_UP, 48'd70368744177664);
      end else begin
        write_reg(REG_BASIS_FWD, {rand_q214(), rand_q214(), rand_q214()});
        write_reg(REG_BASIS_RGT, {rand_q214(), rand_q214(), rand_q214()});
        write_reg(REG_BASIS_UP, {rand_q214(), rand_q214(), rand_q214()});
      end
      // fill every slot so no unwritten key is ever read
      if (ph == 0) begin
        for (int s = 0; s < KMI_MAX_KEYS; s++) begin
          send_item(REQ_LOAD_POS, 4'(s), rand_key(), rand_key(), rand_key(), $urandom);
          send_item(REQ_LOAD_ROT, 4'(s), rand_key(), rand_key(), rand_key(), $urandom);
        end
      end
      send_item(REQ_RESTART, 4'($urandom), $urandom, $urandom, $urandom, $urandom);
      for (int k = 0; k < 60; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
          send_item($urandom_range(0, 1) ? REQ_LOAD_POS : REQ_LOAD_ROT, 4'($urandom),
                    rand_key(), rand_key(), rand_key(), $urandom);
        end else if (pick < 20) begin
          send_item(REQ_RESTART, 4'($urandom), $urandom, $urandom, $urandom, $urandom);
        end else if (pick < 28) begin
          send_item(REQ_TICK, 4'($urandom), $urandom, $urandom, $urandom, $urandom);
        end else begin
          steps = $urandom_range(1, 14);
          send_item(REQ_TICK, 4'($urandom), $urandom, $urandom, $urandom,
                    dur / steps + $urandom_range(0, 3));
        end
      end
      drain();
    end

    repeat (100) @(negedge clk);
    if (fail_count == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

  initial begin
    #8ms;
    $display("testbench: errors");
    $finish;
  end

endmodule

[files.f]
rtl/kmi_pkg.sv
rtl/kmi_ram.sv
rtl/kmi_ctrl.sv
rtl/kmi_datapath.sv
rtl/keyframe_motion_interpolator.sv
tb/kmi_checker.sv
tb/testbench.sv
